FILE: design/pip_pkg.sv
// Shared types, codes and the per-edge step table for the point-in-polygon block.
`timescale 1ns / 1ps

package pip_pkg;

    localparam int STEP_W    = 5;
    localparam int LAST_STEP = 17;

    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_BAND_TOL     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_NEXT,
        ST_DECIDE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_H,
        SH_H1,
        SH_2H
    } shift_t;

    typedef enum logic [3:0] {
        OP_ABX,
        OP_ABY,
        OP_AQX,
        OP_AQY,
        OP_BQX,
        OP_BQY,
        OP_CRL,
        OP_CRH,
        OP_TOL,
        OP_TOL2,
        OP_LENL,
        OP_LENH
    } op_sel_t;

    typedef enum logic [3:0] {
        D_NONE,
        D_TOL2,
        D_LEN2,
        D_DOT,
        D_DA,
        D_DB,
        D_CR,
        D_CRS,
        D_TL,
        D_LHS,
        D_RHS
    } dst_t;

    typedef struct packed {
        logic   mul_en;
        logic   acc_en;
        logic   clr;
        logic   neg;
        shift_t sh;
    } mac_ctrl_t;

    typedef struct packed {
        op_sel_t opa;
        op_sel_t opb;
        logic    clr;
        logic    neg;
        shift_t  sh;
        dst_t    dst;
    } step_op_t;

    // Step 0 squares the tolerance once per query; steps 1..17 run once per edge.
    function automatic step_op_t step_op(input logic [STEP_W-1:0] step);
        step_op_t r;
        r = '{OP_TOL, OP_TOL, 1'b1, 1'b0, SH_0, D_TOL2};
        case (step)
            5'd1:    r = '{OP_ABX,  OP_ABX,  1'b1, 1'b0, SH_0,  D_NONE};
            5'd2:    r = '{OP_ABY,  OP_ABY,  1'b0, 1'b0, SH_0,  D_LEN2};
            5'd3:    r = '{OP_AQX,  OP_ABX,  1'b1, 1'b0, SH_0,  D_NONE};
            5'd4:    r = '{OP_AQY,  OP_ABY,  1'b0, 1'b0, SH_0,  D_DOT};
            5'd5:    r = '{OP_AQX,  OP_AQX,  1'b1, 1'b0, SH_0,  D_NONE};
            5'd6:    r = '{OP_AQY,  OP_AQY,  1'b0, 1'b0, SH_0,  D_DA};
            5'd7:    r = '{OP_BQX,  OP_BQX,  1'b1, 1'b0, SH_0,  D_NONE};
            5'd8:    r = '{OP_BQY,  OP_BQY,  1'b0, 1'b0, SH_0,  D_DB};
            5'd9:    r = '{OP_AQX,  OP_ABY,  1'b1, 1'b0, SH_0,  D_NONE};
            5'd10:   r = '{OP_AQY,  OP_ABX,  1'b0, 1'b1, SH_0,  D_CR};
            5'd11:   r = '{OP_CRL,  OP_CRL,  1'b1, 1'b0, SH_0,  D_NONE};
            5'd12:   r = '{OP_CRH,  OP_CRL,  1'b0, 1'b0, SH_H1, D_NONE};
            5'd13:   r = '{OP_CRH,  OP_CRH,  1'b0, 1'b0, SH_2H, D_CRS};
            5'd14:   r = '{OP_TOL2, OP_LENL, 1'b1, 1'b0, SH_0,  D_NONE};
            5'd15:   r = '{OP_TOL2, OP_LENH, 1'b0, 1'b0, SH_H,  D_TL};
            5'd16:   r = '{OP_BQX,  OP_ABY,  1'b1, 1'b1, SH_0,  D_LHS};
            5'd17:   r = '{OP_BQY,  OP_ABX,  1'b1, 1'b1, SH_0,  D_RHS};
            default: r = '{OP_TOL,  OP_TOL,  1'b1, 1'b0, SH_0,  D_TOL2};
        endcase
        return r;
    endfunction

endpackage

FILE: design/pip_mac.sv
// Shared multiply-accumulate unit: one registered product, then a shifted add into the sum.
`timescale 1ns / 1ps

module pip_mac #(
    parameter int MW    = 33,
    parameter int ACC_W = 132,
    parameter int H     = 26
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pip_pkg::mac_ctrl_t      ctrl,
    input  logic signed [MW-1:0]    opa,
    input  logic signed [MW-1:0]    opb,
    output logic signed [ACC_W-1:0] acc_sum
);
    import pip_pkg::*;

    logic signed [2*MW-1:0]  prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] ext;
    logic signed [ACC_W-1:0] shifted;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] base;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= opa * opb;
        end
    end

    always_comb
    begin
        ext = ACC_W'(prod_reg);
        case (ctrl.sh)
            SH_H:    shifted = ext <<< H;
            SH_H1:   shifted = ext <<< (H + 1);
            SH_2H:   shifted = ext <<< (2 * H);
            default: shifted = ext;
        endcase
        term    = ctrl.neg ? -shifted : shifted;
        base    = ctrl.clr ? '0 : acc_reg;
        acc_sum = base + term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_sum;
        end
    end

endmodule

FILE: design/point_in_polygon_with_band_top.sv
// Top level: vertex store, edge sequencer and decision logic around the shared MAC.
`timescale 1ns / 1ps

// Point-in-polygon test with a tolerance band. Write items (tuser = 0) store one vertex.
// A query item (tuser = 1) returns one word: bit 0 inside, bit 1 near the boundary.
// A query walks the closed polygon one edge at a time through a single shared multiplier;
// each product has a multiply and an accumulate state and an edge needs seventeen of them.
// A query with fewer than three vertices skips the walk. The input is not ready while a
// query runs.
// Configuration: index 0 vertex_count (data[5:0]), index 1 band_tolerance (data[15:0]).
module point_in_polygon_with_band_top #(
    parameter int MAX_VERTICES = 32,
    parameter int COORD_BITS   = 24
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // vertex_index, x_coord, y_coord, zero fill
    input  logic [((5 + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // cmd
    input  logic                                     s_tuser,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // inside_res, near_boundary, zero fill
    output logic [7:0]                               m_tdata,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic                                     cfg_index,
    input  logic [15:0]                              cfg_data
);
    import pip_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int KW    = $clog2(MAX_VERTICES + 1);
    localparam int H     = CB + 2;
    localparam int MW    = (CB + 3 > 33) ? CB + 3 : 33;
    localparam int ACC_W = 4 * MW;

    state_t state_reg, state_next;

    logic [5:0]           vertex_count_reg;
    logic [15:0]          band_tol_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [KW-1:0]        k_reg;
    logic [KW-1:0]        n_reg;
    logic                 near_reg;
    logic                 parity_reg;
    logic                 m_tvalid_reg;
    logic                 inside_out_reg;
    logic                 near_out_reg;

    logic signed [CB-1:0] qx_reg, qy_reg;
    logic signed [CB-1:0] prev_x_reg, prev_y_reg;
    logic signed [CB-1:0] rd_x_reg, rd_y_reg;
    logic signed [CB-1:0] vx_mem [MAX_VERTICES];
    logic signed [CB-1:0] vy_mem [MAX_VERTICES];

    logic [31:0]             tol2_reg;
    logic signed [ACC_W-1:0] len2_reg, dot_reg, da_reg, db_reg, cr_reg;
    logic signed [ACC_W-1:0] crs_reg, tl_reg, lhs_reg, rhs_reg;

    logic                 s_acc;
    logic [4:0]           in_index;
    logic signed [CB-1:0] in_x, in_y;
    logic [31:0]          vc32;
    logic [KW-1:0]        n_sat;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 out_free;

    step_op_t             op;
    mac_ctrl_t            mac_ctrl;
    logic signed [MW-1:0] opa, opb;
    logic signed [ACC_W-1:0] acc_sum;

    logic signed [CB:0]   abx, aby, aqx, aqy, bqx, bqy;
    logic [ACC_W-1:0]     cr_abs;
    logic signed [ACC_W-1:0] tol2_w;
    logic                 edge_near;
    logic                 edge_cross;

    assign in_index = s_tdata[4:0];
    assign in_x     = s_tdata[CB+4:5];
    assign in_y     = s_tdata[2*CB+4:CB+5];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free = !m_tvalid_reg || m_tready;

    assign vc32  = 32'(vertex_count_reg);
    assign n_sat = (vc32 > 32'(MAX_VERTICES)) ? KW'(MAX_VERTICES) : KW'(vc32);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= '0;
            band_tol_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_VERTEX_COUNT: vertex_count_reg <= cfg_data[5:0];
                CFG_BAND_TOL:     band_tol_reg     <= cfg_data;
                default:          band_tol_reg     <= band_tol_reg;
            endcase
        end
    end

    // vertex store
    always_ff @(posedge clk)
    begin
        if (s_acc && !s_tuser && (32'(in_index) < 32'(MAX_VERTICES)))
        begin
            vx_mem[AW'(in_index)] <= in_x;
            vy_mem[AW'(in_index)] <= in_y;
        end
        if (rd_en)
        begin
            rd_x_reg <= vx_mem[rd_addr];
            rd_y_reg <= vy_mem[rd_addr];
        end
    end

    // edge operands: prev is the edge start, the freshly read vertex its end
    assign abx = (CB+1)'(rd_x_reg) - (CB+1)'(prev_x_reg);
    assign aby = (CB+1)'(rd_y_reg) - (CB+1)'(prev_y_reg);
    assign aqx = (CB+1)'(qx_reg)   - (CB+1)'(prev_x_reg);
    assign aqy = (CB+1)'(qy_reg)   - (CB+1)'(prev_y_reg);
    assign bqx = (CB+1)'(qx_reg)   - (CB+1)'(rd_x_reg);
    assign bqy = (CB+1)'(qy_reg)   - (CB+1)'(rd_y_reg);
    assign cr_abs = cr_reg[ACC_W-1] ? ACC_W'(-cr_reg) : ACC_W'(cr_reg);
    assign tol2_w = ACC_W'(tol2_reg);

    assign op = step_op(step_reg);

    function automatic logic signed [MW-1:0] pick(
        input op_sel_t sel,
        input logic signed [CB:0] abx_i, aby_i, aqx_i, aqy_i, bqx_i, bqy_i,
        input logic [ACC_W-1:0] cra,
        input logic [ACC_W-1:0] len2,
        input logic [15:0] tol,
        input logic [31:0] tol2
    );
        logic signed [MW-1:0] r;
        case (sel)
            OP_ABX:  r = MW'(abx_i);
            OP_ABY:  r = MW'(aby_i);
            OP_AQX:  r = MW'(aqx_i);
            OP_AQY:  r = MW'(aqy_i);
            OP_BQX:  r = MW'(bqx_i);
            OP_BQY:  r = MW'(bqy_i);
            OP_CRL:  r = MW'(cra[H-1:0]);
            OP_CRH:  r = MW'(cra[2*H-1:H]);
            OP_TOL:  r = MW'(tol);
            OP_TOL2: r = MW'(tol2);
            OP_LENL: r = MW'(len2[H-1:0]);
            OP_LENH: r = MW'(len2[2*H-1:H]);
            default: r = '0;
        endcase
        return r;
    endfunction

    assign opa = pick(op.opa, abx, aby, aqx, aqy, bqx, bqy, cr_abs, len2_reg,
                      band_tol_reg, tol2_reg);
    assign opb = pick(op.opb, abx, aby, aqx, aqy, bqx, bqy, cr_abs, len2_reg,
                      band_tol_reg, tol2_reg);

    pip_mac #(
        .MW    (MW),
        .ACC_W (ACC_W),
        .H     (H)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .opa     (opa),
        .opb     (opb),
        .acc_sum (acc_sum)
    );

    // per-edge decision from the stored sums
    always_comb
    begin
        if (len2_reg == '0 || dot_reg <= 0)
        begin
            edge_near = (da_reg <= tol2_w);
        end
        else if (dot_reg >= len2_reg)
        begin
            edge_near = (db_reg <= tol2_w);
        end
        else
        begin
            edge_near = (crs_reg <= tl_reg);
        end
        // crossing edge runs from the read vertex back to prev; dy = prev_y - cur_y = -aby
        edge_cross = 1'b0;
        if ((rd_y_reg > qy_reg) != (prev_y_reg > qy_reg))
        begin
            if (aby < 0)
            begin
                edge_cross = (lhs_reg < rhs_reg);
            end
            else if (aby > 0)
            begin
                edge_cross = (lhs_reg > rhs_reg);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && s_tuser)
                begin
                    state_next = (n_sat < KW'(3)) ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_NEXT;
                end
                else if (step_reg == STEP_W'(LAST_STEP))
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_NEXT:
            begin
                state_next = ST_MUL;
            end
            ST_DECIDE:
            begin
                state_next = (k_reg == n_reg) ? ST_DONE : ST_NEXT;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        mac_ctrl = '{1'b0, 1'b0, op.clr, op.neg, op.sh};
        rd_en    = 1'b0;
        rd_addr  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                rd_en = s_acc && s_tuser;
            end
            ST_MUL:
            begin
                mac_ctrl.mul_en = 1'b1;
            end
            ST_ACC:
            begin
                mac_ctrl.acc_en = 1'b1;
            end
            ST_NEXT:
            begin
                // wrap the closing edge back to vertex zero
                rd_en   = 1'b1;
                rd_addr = (k_reg == n_reg) ? '0 : k_reg[AW-1:0];
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            k_reg          <= '0;
            n_reg          <= '0;
            near_reg       <= 1'b0;
            parity_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            inside_out_reg <= 1'b0;
            near_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_acc && s_tuser)
                    begin
                        step_reg   <= '0;
                        k_reg      <= KW'(1);
                        n_reg      <= n_sat;
                        near_reg   <= 1'b0;
                        parity_reg <= 1'b0;
                    end
                end
                ST_ACC:
                begin
                    if (step_reg != STEP_W'(LAST_STEP))
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_DECIDE:
                begin
                    near_reg   <= near_reg | edge_near;
                    parity_reg <= parity_reg ^ edge_cross;
                    step_reg   <= STEP_W'(1);
                    if (k_reg != n_reg)
                    begin
                        k_reg <= k_reg + KW'(1);
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        inside_out_reg <= near_reg | parity_reg;
                        near_out_reg   <= near_reg;
                    end
                end
                default:
                begin
                    step_reg <= step_reg;
                end
            endcase
        end
    end

    // query point, edge start and stored sums
    always_ff @(posedge clk)
    begin
        if (s_acc && s_tuser)
        begin
            qx_reg <= in_x;
            qy_reg <= in_y;
        end
        if (state_reg == ST_NEXT)
        begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
        end
        if (state_reg == ST_ACC)
        begin
            case (op.dst)
                D_TOL2:  tol2_reg <= acc_sum[31:0];
                D_LEN2:  len2_reg <= acc_sum;
                D_DOT:   dot_reg  <= acc_sum;
                D_DA:    da_reg   <= acc_sum;
                D_DB:    db_reg   <= acc_sum;
                D_CR:    cr_reg   <= acc_sum;
                D_CRS:   crs_reg  <= acc_sum;
                D_TL:    tl_reg   <= acc_sum;
                D_LHS:   lhs_reg  <= acc_sum;
                D_RHS:   rhs_reg  <= acc_sum;
                default: tol2_reg <= tol2_reg;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, near_out_reg, inside_out_reg};

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_W'(LAST_STEP))
        else $error("step counter out of range");

    a_edge_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && state_reg != ST_DONE) |-> (k_reg <= n_reg && n_reg >= KW'(3)))
        else $error("edge counter beyond vertex count");

    a_near_inside: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (!near_out_reg || inside_out_reg))
        else $error("near boundary without inside");

    a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> m_tvalid_reg)
        else $error("result word not loaded");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the point-in-polygon block with a boundary band.
`timescale 1ns / 1ps

module testbench;
    import pip_pkg::*;

    localparam int NV         = 32;
    localparam int CB         = 24;
    localparam int TDW        = 56;
    localparam int QUIET_MAX  = 40000;
    localparam int PLAN_ITEMS = 1600;
    localparam bit CMD_WRITE  = 1'b0;
    localparam bit CMD_QUERY  = 1'b1;

    typedef logic signed [127:0] wide_t;
    typedef struct packed {
        logic in_poly;
        logic near;
    } verdict_t;
    typedef struct {
        bit          is_cfg;
        logic        cidx;
        int unsigned cval;
        bit          cmd;
        int          idx;
        int          x;
        int          y;
        bit          fixed;
        verdict_t    want;
    } stim_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [TDW-1:0]   s_tdata = '0;
    logic             s_tuser = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [7:0]       m_tdata;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_index = CFG_VERTEX_COUNT;
    logic [15:0]      cfg_data = '0;

    // Shadow of the block: vertex store and registers.
    longint           poly_east[NV];
    longint           poly_north[NV];
    logic [5:0]       shadow_count = '0;
    logic [15:0]      shadow_tol = '0;

    verdict_t         pending_verdicts[$];
    int               errors = 0;
    int               items_sent = 0;
    int               writes_sent = 0;
    int               queries_sent = 0;
    int               inside_seen = 0;
    int               near_seen = 0;
    int               gap_pct = 7;
    int               stall_pct = 88;
    int               quiet = 0;

    point_in_polygon_with_band_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic bit seg_within_band(longint qx, longint qy, longint ax, longint ay,
                                           longint bx, longint by, wide_t tol2);
        longint abx, aby, aqx, aqy, len2, dotv, d2, cr;
        abx  = bx - ax;
        aby  = by - ay;
        aqx  = qx - ax;
        aqy  = qy - ay;
        len2 = abx * abx + aby * aby;
        dotv = aqx * abx + aqy * aby;
        if (len2 == 0 || dotv <= 0)
        begin
            d2 = aqx * aqx + aqy * aqy;
            return wide_t'(d2) <= tol2;
        end
        if (dotv >= len2)
        begin
            d2 = (qx - bx) * (qx - bx) + (qy - by) * (qy - by);
            return wide_t'(d2) <= tol2;
        end
        cr = aqx * aby - aqy * abx;
        return wide_t'(cr) * wide_t'(cr) <= tol2 * wide_t'(len2);
    endfunction

    function automatic verdict_t classify_point(longint qx, longint qy);
        verdict_t v;
        int       n, j, nx;
        bit       near, odd;
        wide_t    tol2;
        longint   ax, ay, bx, by, dy, lhs, rhs;
        v    = '0;
        n    = (shadow_count > NV) ? NV : int'(shadow_count);
        near = 1'b0;
        odd  = 1'b0;
        if (n < 3)
            return v;
        tol2 = wide_t'(shadow_tol) * wide_t'(shadow_tol);
        for (int i = 0; i < n; i++)
        begin
            nx = (i + 1 == n) ? 0 : i + 1;
            if (seg_within_band(qx, qy, poly_east[i], poly_north[i],
                                poly_east[nx], poly_north[nx], tol2))
                near = 1'b1;
        end
        j = n - 1;
        for (int i = 0; i < n; i++)
        begin
            ax = poly_east[i];
            ay = poly_north[i];
            bx = poly_east[j];
            by = poly_north[j];
            // half-open rule: the edge counts when it straddles the query row
            if ((ay > qy) != (by > qy))
            begin
                dy  = by - ay;
                lhs = (qx - ax) * dy;
                rhs = (qy - ay) * (bx - ax);
                if ((dy > 0 && lhs < rhs) || (dy < 0 && lhs > rhs))
                    odd = ~odd;
            end
            j = i;
        end
        v.in_poly = near | odd;
        v.near    = near;
        return v;
    endfunction

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        $display("MISMATCH at %0t: %s expected %0d got %0d", $time, what, want, got);
        errors++;
    endtask

    // Result side: check each word, then pick the stall for the next cycle.
    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_verdicts.size() == 0)
                    report_mismatch("unexpected result word, count", 0, 1);
                else
                begin
                    v = pending_verdicts.pop_front();
                    if (m_tdata[0] !== v.in_poly)
                        report_mismatch("inside_res", v.in_poly, m_tdata[0]);
                    if (m_tdata[1] !== v.near)
                        report_mismatch("near_boundary", v.near, m_tdata[1]);
                    inside_seen += m_tdata[0];
                    near_seen   += m_tdata[1];
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_MAX)
        begin
            $display("Timeout: no handshake for %0d cycles", QUIET_MAX);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_item(bit cmd, logic [4:0] idx, logic signed [CB-1:0] x,
                             logic signed [CB-1:0] y, bit use_fixed, verdict_t fixed_v);
        // three idle profiles over the run: sparse receiver, sparse sender, none
        if (items_sent < PLAN_ITEMS / 3)
        begin
            gap_pct   = 7;
            stall_pct = 88;
        end
        else if (items_sent < 2 * PLAN_ITEMS / 3)
        begin
            gap_pct   = 88;
            stall_pct = 7;
        end
        else
        begin
            gap_pct   = 0;
            stall_pct = 0;
        end
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, y, x, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        if (cmd == CMD_WRITE)
        begin
            poly_east[idx]  = x;
            poly_north[idx] = y;
            writes_sent++;
        end
        else
        begin
            pending_verdicts.push_back(use_fixed ? fixed_v : classify_point(x, y));
            queries_sent++;
        end
    endtask

    task automatic write_reg(logic ridx, logic [15:0] val);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        // a trailing vertex write produces no word; let it settle
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= ridx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (ridx == CFG_VERTEX_COUNT)
            shadow_count = val[5:0];
        else
            shadow_tol = val;
    endtask

    function automatic logic signed [CB-1:0] pick_coord(longint center, longint spread);
        longint v;
        if (spread >= 4194304)
            return CB'($urandom);
        v = center + longint'($urandom_range(2 * spread)) - spread;
        if (v > 8388607)
            v = 8388607;
        if (v < -8388608)
            v = -8388608;
        return CB'(v);
    endfunction

    function automatic stim_row_t cfg_row(logic ridx, int unsigned val);
        stim_row_t r;
        r        = '{default: 0};
        r.is_cfg = 1'b1;
        r.cidx   = ridx;
        r.cval   = val;
        return r;
    endfunction

    function automatic stim_row_t item_row(bit cmd, int idx, int x, int y);
        stim_row_t r;
        r     = '{default: 0};
        r.cmd = cmd;
        r.idx = idx;
        r.x   = x;
        r.y   = y;
        return r;
    endfunction

    function automatic stim_row_t known_row(int x, int y, verdict_t want);
        stim_row_t r;
        r       = item_row(CMD_QUERY, 0, x, y);
        r.fixed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    initial
    begin
        stim_row_t   plan[$];
        int          n_tab[10]   = '{3, 4, 5, 8, 3, 32, 6, 2, 12, 63};
        int          sprd_tab[10] = '{64, 1000, 8388607, 5000, 200, 300000, 8388607, 1000,
                                      20000, 3000};
        int          n_eff, spread, tol_max;
        longint      cx, cy;
        int unsigned tol;

        for (int i = 0; i < NV; i++)
        begin
            poly_east[i]  = 0;
            poly_north[i] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every slot so that any vertex count reads written vertices only.
        for (int i = 0; i < NV; i++)
            send_item(CMD_WRITE, 5'(i), (i % 2) ? 24'sh7fffff : 24'sh800000, CB'($urandom),
                      1'b0, '0);

        plan.push_back(known_row(0, 0, '{1'b0, 1'b0}));
        plan.push_back(item_row(CMD_WRITE, 0, -1000, -1000));
        plan.push_back(item_row(CMD_WRITE, 1, 1000, -1000));
        plan.push_back(item_row(CMD_WRITE, 2, 1000, 1000));
        plan.push_back(item_row(CMD_WRITE, 3, -1000, 1000));
        plan.push_back(cfg_row(CFG_VERTEX_COUNT, 4));
        plan.push_back(item_row(CMD_QUERY, 0, 0, 0));
        plan.push_back(item_row(CMD_QUERY, 0, 2000, 0));
        plan.push_back(item_row(CMD_QUERY, 0, 1000, 0));
        plan.push_back(item_row(CMD_QUERY, 0, -1000, -1000));
        plan.push_back(cfg_row(CFG_BAND_TOL, 65535));
        plan.push_back(item_row(CMD_QUERY, 0, 1200, 5000));
        plan.push_back(item_row(CMD_QUERY, 0, -8388608, -8388608));
        plan.push_back(item_row(CMD_QUERY, 0, 8388607, 8388607));
        plan.push_back(cfg_row(CFG_VERTEX_COUNT, 2));
        plan.push_back(known_row(0, 0, '{1'b0, 1'b0}));
        plan.push_back(cfg_row(CFG_VERTEX_COUNT, 3));
        plan.push_back(cfg_row(CFG_BAND_TOL, 0));
        // zero-length closing edge: slot 2 repeats slot 0
        plan.push_back(item_row(CMD_WRITE, 2, -1000, -1000));
        plan.push_back(item_row(CMD_QUERY, 0, -1000, -1000));
        plan.push_back(item_row(CMD_QUERY, 0, -1001, -1000));
        // count above capacity saturates to all slots
        plan.push_back(cfg_row(CFG_VERTEX_COUNT, 63));
        plan.push_back(item_row(CMD_QUERY, 0, 0, 0));
        plan.push_back(item_row(CMD_WRITE, 31, 8388607, -8388608));
        plan.push_back(item_row(CMD_QUERY, 0, 8388607, -8388608));
        plan.push_back(item_row(CMD_QUERY, 0, 123, -77));

        foreach (plan[k])
        begin
            if (plan[k].is_cfg)
                write_reg(plan[k].cidx, 16'(plan[k].cval));
            else
                send_item(plan[k].cmd, 5'(plan[k].idx), CB'(plan[k].x), CB'(plan[k].y),
                          plan[k].fixed, plan[k].want);
        end

        // Random phases: new polygon and registers each time, then mixed traffic.
        for (int p = 0; p < 10; p++)
        begin
            spread  = sprd_tab[p];
            n_eff   = (n_tab[p] > NV) ? NV : n_tab[p];
            cx      = longint'($urandom_range(2000000)) - 1000000;
            cy      = longint'($urandom_range(2000000)) - 1000000;
            tol_max = (spread / 3 > 65535) ? 65535 : spread / 3;
            case (p % 3)
                0:       tol = $urandom_range(tol_max);
                1:       tol = (p == 7) ? 65535 : 0;
                default: tol = $urandom_range(65535);
            endcase
            write_reg(CFG_BAND_TOL, 16'(tol));
            write_reg(CFG_VERTEX_COUNT, 16'(n_tab[p]));
            for (int i = 0; i < n_eff; i++)
                send_item(CMD_WRITE, 5'(i), pick_coord(cx, spread), pick_coord(cy, spread),
                          1'b0, '0);
            for (int k = 0; k < 150 - n_eff; k++)
            begin
                if ($urandom_range(99) < 60)
                    send_item(CMD_QUERY, 5'($urandom), pick_coord(cx, spread + spread / 3),
                              pick_coord(cy, spread + spread / 3), 1'b0, '0);
                else if ($urandom_range(99) < 70)
                    send_item(CMD_WRITE, 5'($urandom_range(n_eff - 1)),
                              pick_coord(cx, spread), pick_coord(cy, spread), 1'b0, '0);
                else
                    send_item(CMD_WRITE, 5'($urandom), CB'($urandom), CB'($urandom),
                              1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (1200) @(posedge clk);

        $display("Covered %0d vertex writes and %0d queries over ten polygon settings",
                 writes_sent, queries_sent);
        $display("Results: %0d inside, %0d within the band", inside_seen, near_seen);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: point_in_polygon_with_band_top.f
design/pip_pkg.sv
design/pip_mac.sv
design/point_in_polygon_with_band_top.sv
sim/testbench.sv
